FILE: rtl/kfs_pkg.sv
package kfs_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [1:0] CMD_SEARCH  = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] id;
      logic [55:0] key;
      logic [63:0] desc_a;
      logic [63:0] desc_b;
      logic [23:0] desc_c;
   } record_type;

   typedef struct packed {
      logic load;
      logic shift;
   } chain_ctl_type;

   // Every byte after the first zero byte is cleared; the first character is
   // the most significant byte.
   function automatic logic [55:0] cut_key(input logic [55:0] v);
      logic        ended;
      logic [55:0] r;
      ended = 1'b0;
      r = '0;
      for (int i = 6; i >= 0; i--) begin
         if (v[i*8 +: 8] == 8'h00) ended = 1'b1;
         if (!ended) r[i*8 +: 8] = v[i*8 +: 8];
      end
      return r;
   endfunction

   function automatic logic [151:0] cut_desc(input logic [151:0] v);
      logic         ended;
      logic [151:0] r;
      ended = 1'b0;
      r = '0;
      for (int i = 18; i >= 0; i--) begin
         if (v[i*8 +: 8] == 8'h00) ended = 1'b1;
         if (!ended) r[i*8 +: 8] = v[i*8 +: 8];
      end
      return r;
   endfunction

endpackage

FILE: rtl/kfs_if.sv
interface kfs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [55:0] key_text;
   logic [63:0] desc_part_a;
   logic [63:0] desc_part_b;
   logic [23:0] desc_part_c;

   modport source (output valid, cmd, key_text, desc_part_a, desc_part_b, desc_part_c,
                   input ready);
   modport sink (input valid, cmd, key_text, desc_part_a, desc_part_b, desc_part_c,
                 output ready);
endinterface

interface kfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [4:0]  position;
   logic [31:0] record_id;
   logic [55:0] record_key;
   logic [63:0] record_desc_a;
   logic [63:0] record_desc_b;
   logic [23:0] record_desc_c;

   modport source (output valid, status, position, record_id, record_key, record_desc_a,
                   record_desc_b, record_desc_c, input ready);
   modport sink (input valid, status, position, record_id, record_key, record_desc_a,
                 record_desc_b, record_desc_c, output ready);
endinterface

FILE: rtl/kfs_cell.sv
module kfs_cell (
   input  logic                  clock,
   input  logic                  load,
   input  logic                  shift,
   input  kfs_pkg::record_type   load_rec,
   input  kfs_pkg::record_type   next_rec,
   output kfs_pkg::record_type   rec
);

   kfs_pkg::record_type rec_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= load_rec;
      end else if (shift) begin
         rec_ff <= next_rec;
      end
   end

   assign rec = rec_ff;

endmodule

FILE: rtl/kfs_chain.sv
module kfs_chain #(
   parameter int DEPTH = kfs_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  kfs_pkg::chain_ctl_type ctl,
   input  logic [AW-1:0]          load_index,
   input  kfs_pkg::record_type    load_rec,
   output kfs_pkg::record_type    head_rec
);

   kfs_pkg::record_type rec [DEPTH];

   // The cells form a ring: each one takes its upper neighbor on a shift, and the
   // last one takes the head, so a full sweep of DEPTH shifts restores the order.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int NEXT = (i + 1) % DEPTH;
      kfs_cell u_cell (
         .clock    (clock),
         .load     (ctl.load && (load_index == AW'(i))),
         .shift    (ctl.shift),
         .load_rec (load_rec),
         .next_rec (rec[NEXT]),
         .rec      (rec[i])
      );
   end

   assign head_rec = rec[0];

endmodule

FILE: rtl/keyed_fifo_with_search_top.sv
// Keyed FIFO with search. Records live in a ring of DEPTH cells with the queue
// head always in cell 0; a dequeue shifts the ring by one, and an enqueue loads
// the cell just past the last occupied one. Enqueue, dequeue and a search of an
// empty queue go from idle straight to the finishing state, which registers the
// result and returns to idle once the output register is free. The unused
// command is accepted and dropped without a result. A search of a non-empty
// queue first shifts the whole ring once around, comparing the head cell's key
// at each shift while it holds an occupied entry, then goes to the finishing state.
// One item is worked on at a time: the next item is accepted once the block is
// idle again, even while the previous result still waits in the output register.
module keyed_fifo_with_search_top #(
   parameter int DEPTH = kfs_pkg::DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   kfs_req_if.sink   req_chan,
   kfs_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [1:0]            cmd_ff, cmd_in;
   logic [55:0]           key_ff, key_in;
   kfs_pkg::record_type   new_rec_ff, new_rec_in;
   logic [AW-1:0]         step_ff, step_in;
   logic                  found_ff, found_in;
   logic [CW-1:0]         pos_ff, pos_in;
   kfs_pkg::record_type   match_rec_ff, match_rec_in;
   logic [CW-1:0]         occ_ff, occ_in;
   logic [31:0]           id_ff, id_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kfs_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [4:0]            rsp_pos_ff, rsp_pos_in;
   kfs_pkg::record_type   rsp_rec_ff, rsp_rec_in;

   kfs_pkg::chain_ctl_type chain_ctl;
   kfs_pkg::record_type    head_rec;
   kfs_pkg::record_type    load_rec;

   logic                  accept;
   logic                  out_free;
   logic                  is_full;
   logic                  is_empty;
   logic [151:0]          desc_cut;
   logic [31:0]           pos_wide;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign is_full  = (occ_ff == CW'(DEPTH));
   assign is_empty = (occ_ff == '0);
   assign desc_cut = kfs_pkg::cut_desc({req_chan.desc_part_a, req_chan.desc_part_b,
                                        req_chan.desc_part_c});
   assign pos_wide = 32'(pos_ff);

   always_comb begin
      load_rec    = new_rec_ff;
      load_rec.id = id_ff + 32'd1;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      new_rec_in    = new_rec_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      match_rec_in  = match_rec_ff;
      occ_in        = occ_ff;
      id_in         = id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_rec_in    = rsp_rec_ff;
      chain_ctl     = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_chan.cmd != kfs_pkg::CMD_UNUSED)) begin
               cmd_in            = req_chan.cmd;
               key_in            = kfs_pkg::cut_key(req_chan.key_text);
               new_rec_in.id     = '0;
               new_rec_in.key    = kfs_pkg::cut_key(req_chan.key_text);
               new_rec_in.desc_a = desc_cut[151:88];
               new_rec_in.desc_b = desc_cut[87:24];
               new_rec_in.desc_c = desc_cut[23:0];
               step_in           = '0;
               found_in          = 1'b0;
               if ((req_chan.cmd == kfs_pkg::CMD_SEARCH) && !is_empty) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SEARCH: begin
            chain_ctl.shift = 1'b1;
            if (!found_in && (CW'(step_ff) < occ_ff) && (head_rec.key == key_ff)) begin
               found_in     = 1'b1;
               pos_in       = CW'(step_ff) + CW'(1);
               match_rec_in = head_rec;
            end
            step_in = step_ff + AW'(1);
            if (step_ff == AW'(DEPTH - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = kfs_pkg::STATUS_OK;
               rsp_pos_in    = '0;
               rsp_rec_in    = '0;
               case (cmd_ff)
                  kfs_pkg::CMD_ENQUEUE: begin
                     if (is_full) begin
                        rsp_status_in = kfs_pkg::STATUS_FULL;
                     end else begin
                        chain_ctl.load = 1'b1;
                        rsp_rec_in.id  = load_rec.id;
                        id_in          = load_rec.id;
                        occ_in         = occ_ff + CW'(1);
                     end
                  end
                  kfs_pkg::CMD_DEQUEUE: begin
                     if (is_empty) begin
                        rsp_status_in = kfs_pkg::STATUS_EMPTY;
                     end else begin
                        chain_ctl.shift = 1'b1;
                        rsp_rec_in      = head_rec;
                        occ_in          = occ_ff - CW'(1);
                     end
                  end
                  default: begin
                     if (is_empty) begin
                        rsp_status_in = kfs_pkg::STATUS_EMPTY;
                     end else if (found_ff) begin
                        rsp_rec_in = match_rec_ff;
                        rsp_pos_in = pos_wide[4:0];
                     end else begin
                        rsp_status_in = kfs_pkg::STATUS_NOT_FOUND;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         id_ff        <= '0;
         found_ff     <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         id_ff        <= id_in;
         found_ff     <= found_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      new_rec_ff    <= new_rec_in;
      pos_ff        <= pos_in;
      match_rec_ff  <= match_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_rec_ff    <= rsp_rec_in;
   end

   kfs_chain #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_chain (
      .clock      (clock),
      .ctl        (chain_ctl),
      .load_index (occ_ff[AW-1:0]),
      .load_rec   (load_rec),
      .head_rec   (head_rec)
   );

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.position      = rsp_pos_ff;
   assign rsp_chan.record_id     = rsp_rec_ff.id;
   assign rsp_chan.record_key    = rsp_rec_ff.key;
   assign rsp_chan.record_desc_a = rsp_rec_ff.desc_a;
   assign rsp_chan.record_desc_b = rsp_rec_ff.desc_b;
   assign rsp_chan.record_desc_c = rsp_rec_ff.desc_c;

   assert property (@(posedge clock) disable iff (reset) occ_ff <= CW'(DEPTH))
      else $error("Occupancy exceeds the queue depth.");

   assert property (@(posedge clock) disable iff (reset) !(chain_ctl.load && chain_ctl.shift))
      else $error("The chain is loaded and shifted in the same cycle.");

   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("A result appeared without a finishing step.");

   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == S_SEARCH) && (step_ff == AW'(DEPTH - 1)) |=>
                    (state_ff == S_FINISH))
      else $error("A search sweep did not end after one full turn of the ring.");

endmodule

FILE: verif/tb.sv
module tb;

   localparam int DEPTH = kfs_pkg::DEPTH_DEFAULT;
   localparam int ITEMS_PER_PHASE = 248;
   localparam int MAX_SHOWN = 10;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct packed {
      kfs_pkg::status_type  status;
      logic [4:0]           position;
      kfs_pkg::record_type  rec;
   } reply_type;

   // Keeps its own copy of the queue, works out the reply for every accepted item
   // but the unused command, and compares the replies of the block in order.
   class queue_scoreboard;
      kfs_pkg::record_type  slots[DEPTH];
      int unsigned head;
      int unsigned tail;
      int unsigned count;
      logic [31:0] last_id;
      reply_type   expected_replies[$];
      int          errors;
      int          replies_seen;
      int          cmd_seen[4];
      int          full_hits;
      int          empty_hits;
      int          misses;
      int          found_count;

      function new();
         head = 0;
         tail = 0;
         count = 0;
         last_id = '0;
         errors = 0;
         replies_seen = 0;
         full_hits = 0;
         empty_hits = 0;
         misses = 0;
         found_count = 0;
         foreach (cmd_seen[i]) cmd_seen[i] = 0;
      endfunction

      // Text is kept only up to its first zero byte; the first byte is the
      // most significant of the nbytes low bytes.
      function logic [151:0] clip_text(logic [151:0] v, int nbytes);
         logic [151:0] r;
         logic         ended;
         r = '0;
         ended = 1'b0;
         for (int i = nbytes - 1; i >= 0; i--) begin
            if (v[i*8 +: 8] == 8'h00) ended = 1'b1;
            if (!ended) r[i*8 +: 8] = v[i*8 +: 8];
         end
         return r;
      endfunction

      function void note_request(logic [1:0] cmd, logic [55:0] key_text, logic [151:0] desc);
         reply_type    r;
         logic [151:0] clipped;
         logic [55:0]  key;
         int unsigned  idx;
         bit           found;
         r = '0;
         found = 1'b0;
         clipped = clip_text({96'd0, key_text}, 7);
         key = clipped[55:0];
         cmd_seen[cmd]++;
         if (cmd == kfs_pkg::CMD_UNUSED) return;
         if (cmd == kfs_pkg::CMD_ENQUEUE) begin
            if (count >= DEPTH) begin
               r.status = kfs_pkg::STATUS_FULL;
               full_hits++;
            end else begin
               last_id = last_id + 32'd1;
               clipped = clip_text(desc, 19);
               slots[tail].id = last_id;
               slots[tail].key = key;
               slots[tail].desc_a = clipped[151:88];
               slots[tail].desc_b = clipped[87:24];
               slots[tail].desc_c = clipped[23:0];
               tail = (tail + 1) % DEPTH;
               count++;
               r.status = kfs_pkg::STATUS_OK;
               r.rec.id = last_id;
            end
         end else if (count == 0) begin
            r.status = kfs_pkg::STATUS_EMPTY;
            empty_hits++;
         end else if (cmd == kfs_pkg::CMD_DEQUEUE) begin
            r.status = kfs_pkg::STATUS_OK;
            r.rec = slots[head];
            head = (head + 1) % DEPTH;
            count--;
         end else begin
            for (int p = 1; p <= count; p++) begin
               idx = (head + p - 1) % DEPTH;
               if (!found && slots[idx].key == key) begin
                  found = 1'b1;
                  r.status = kfs_pkg::STATUS_OK;
                  r.position = 5'(p);
                  r.rec = slots[idx];
               end
            end
            if (found) begin
               found_count++;
            end else begin
               r.status = kfs_pkg::STATUS_NOT_FOUND;
               misses++;
            end
         end
         expected_replies.push_back(r);
      endfunction

      function void check_reply(reply_type got);
         reply_type want;
         if (expected_replies.size() == 0) begin
            errors++;
            if (errors <= MAX_SHOWN)
               $display("%0t: reply with none pending: status %0d pos %0d id %0d", $realtime,
                        got.status, got.position, got.rec.id);
            return;
         end
         want = expected_replies.pop_front();
         replies_seen++;
         if (got.status !== want.status || got.position !== want.position ||
             got.rec.id !== want.rec.id || got.rec.key !== want.rec.key ||
             got.rec.desc_a !== want.rec.desc_a || got.rec.desc_b !== want.rec.desc_b ||
             got.rec.desc_c !== want.rec.desc_c) begin
            errors++;
            if (errors <= MAX_SHOWN) begin
               $display("%0t: reply %0d mismatch", $realtime, replies_seen);
               $display("  expected status %0d pos %0d id %0d key %h desc %h %h %h",
                        want.status, want.position, want.rec.id, want.rec.key,
                        want.rec.desc_a, want.rec.desc_b, want.rec.desc_c);
               $display("  actual   status %0d pos %0d id %0d key %h desc %h %h %h",
                        got.status, got.position, got.rec.id, got.rec.key,
                        got.rec.desc_a, got.rec.desc_b, got.rec.desc_c);
            end
         end
      endfunction

      function void report_leftover();
         if (expected_replies.size() != 0) begin
            errors++;
            $display("%0d expected replies never arrived", expected_replies.size());
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   rsp_hold_request;
   logic [55:0] key_pool[8];

   kfs_req_if req_if();
   kfs_rsp_if rsp_if();

   queue_scoreboard sb = new();

   keyed_fifo_with_search_top #(.DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d replies still pending", sb.expected_replies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_reply({kfs_pkg::status_type'(rsp_if.status), rsp_if.position,
                            rsp_if.record_id, rsp_if.record_key, rsp_if.record_desc_a,
                            rsp_if.record_desc_b, rsp_if.record_desc_c});
         @(negedge clock);
         if (hold_left == 0 && rsp_hold_request > 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance with
   // valid still high, so that a back-to-back item does not toggle it.
   task automatic send_item(logic [1:0] cmd, logic [55:0] key, logic [151:0] desc);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.key_text <= key;
      req_if.desc_part_a <= desc[151:88];
      req_if.desc_part_b <= desc[87:24];
      req_if.desc_part_c <= desc[23:0];
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(cmd, key, desc);
      @(negedge clock);
   endtask

   task automatic wait_for_replies();
      req_if.valid <= 1'b0;
      while (sb.expected_replies.size() != 0) @(negedge clock);
   endtask

   function automatic logic [55:0] smear_after_nul(logic [55:0] k);
      logic [55:0] r;
      logic        ended;
      r = k;
      ended = 1'b0;
      for (int i = 6; i >= 0; i--) begin
         if (ended) r[i*8 +: 8] = 8'($urandom);
         if (k[i*8 +: 8] == 8'h00) ended = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [55:0] random_key();
      int unsigned roll;
      int unsigned len;
      logic [55:0] k;
      roll = $urandom_range(99);
      k = '0;
      if (roll < 60) begin
         k = key_pool[$urandom_range(7)];
      end else if (roll < 85) begin
         k = {$urandom, 24'($urandom)};
      end else begin
         len = $urandom_range(1, 7);
         for (int i = 0; i < len; i++) k[(6 - i)*8 +: 8] = 8'($urandom_range(1, 255));
      end
      if ($urandom_range(1) == 1) k = smear_after_nul(k);
      return k;
   endfunction

   function automatic logic [55:0] search_key();
      int unsigned idx;
      if (sb.count != 0 && $urandom_range(99) < 60) begin
         idx = (sb.head + $urandom_range(sb.count - 1)) % DEPTH;
         return smear_after_nul(sb.slots[idx].key);
      end
      return random_key();
   endfunction

   function automatic logic [151:0] random_desc();
      int unsigned  roll;
      logic [151:0] d;
      roll = $urandom_range(99);
      d = {$urandom, $urandom, $urandom, $urandom, 24'($urandom)};
      if (roll < 8) d = '0;
      else if (roll < 16) d = '1;
      else if (roll >= 50) d[(18 - $urandom_range(18))*8 +: 8] = 8'h00;
      return d;
   endfunction

   function automatic logic [1:0] pick_cmd(int drift);
      int unsigned roll;
      int unsigned enq_share;
      roll = $urandom_range(99);
      enq_share = (drift == 1) ? 80 : (drift == 2) ? 25 : 50;
      if (roll < 3) return kfs_pkg::CMD_UNUSED;
      if (roll < 33) return kfs_pkg::CMD_SEARCH;
      if ($urandom_range(99) < enq_share) return kfs_pkg::CMD_ENQUEUE;
      return kfs_pkg::CMD_DEQUEUE;
   endfunction

   task automatic run_directed();
      send_item(kfs_pkg::CMD_DEQUEUE, '0, '0);
      send_item(kfs_pkg::CMD_SEARCH, 56'h41_4C_50_48_41_00_00, '0);
      send_item(kfs_pkg::CMD_UNUSED, '1, '1);
      send_item(kfs_pkg::CMD_ENQUEUE, '0, '0);
      send_item(kfs_pkg::CMD_ENQUEUE, '1, '1);
      send_item(kfs_pkg::CMD_ENQUEUE, 56'h41_42_00_7F_55_AA_01,
                {64'h48_49_00_DE_AD_BE_EF_01, 64'hFF_FF_FF_FF_FF_FF_FF_FF, 24'h12_34_56});
      send_item(kfs_pkg::CMD_SEARCH, 56'h41_42_00_13_37_00_FF, '1);
      send_item(kfs_pkg::CMD_SEARCH, 56'h41_42_43_00_00_00_00, '0);
      send_item(kfs_pkg::CMD_SEARCH, '1, '0);
      for (int n = 0; n < DEPTH - 3; n++)
         send_item(kfs_pkg::CMD_ENQUEUE, {24'h4B_45_59, 8'(8'h30 + n), 24'h41_41_41},
                   {64'h54_45_58_54_20_20_20_20, 64'(n), 24'h41_42_43});
      send_item(kfs_pkg::CMD_ENQUEUE, 56'h5A_5A_00_00_00_00_00, random_desc());
      send_item(kfs_pkg::CMD_SEARCH, {24'h4B_45_59, 8'(8'h30 + DEPTH - 4), 24'h41_41_41},
                '0);
      send_item(kfs_pkg::CMD_DEQUEUE, '1, '1);
      send_item(kfs_pkg::CMD_SEARCH, 56'h00_FF_FF_FF_FF_FF_FF, '0);
      wait_for_replies();
   endtask

   task automatic run_random(bit with_long_hold);
      int          counted;
      int          drift;
      logic [1:0]  cmd;
      logic [55:0] key;
      counted = 0;
      drift = 0;
      while (counted < ITEMS_PER_PHASE) begin
         if ($urandom_range(39) == 0) drift = $urandom_range(2);
         if (with_long_hold && counted == 40) rsp_hold_request = LONG_HOLD_CYCLES;
         cmd = pick_cmd(drift);
         key = (cmd == kfs_pkg::CMD_SEARCH) ? search_key() : random_key();
         send_item(cmd, key, random_desc());
         if (cmd != kfs_pkg::CMD_UNUSED) counted++;
      end
      wait_for_replies();
   endtask

   initial begin
      reset = 1'b1;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      rsp_hold_request = 0;
      req_if.valid = 1'b0;
      req_if.cmd = kfs_pkg::CMD_ENQUEUE;
      req_if.key_text = '0;
      req_if.desc_part_a = '0;
      req_if.desc_part_b = '0;
      req_if.desc_part_c = '0;
      rsp_if.ready = 1'b0;
      key_pool[0] = 56'h41_4C_50_48_41_00_00;
      key_pool[1] = 56'h5A_00_00_00_00_00_00;
      key_pool[2] = 56'hFF_FF_FF_FF_FF_FF_FF;
      key_pool[3] = 56'h01_02_03_04_05_06_07;
      key_pool[4] = 56'h4B_45_59_30_30_30_31;
      key_pool[5] = 56'h4B_45_59_30_30_30_32;
      key_pool[6] = 56'h00_00_00_00_00_00_00;
      key_pool[7] = 56'h80_7F_00_00_00_00_00;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 53 : (phase == 3) ? 17 : 0;
         recv_stall_pct = (phase == 2) ? 53 : (phase == 3) ? 17 : 0;
         run_random(phase == 0);
      end

      repeat (DEPTH + 8) @(negedge clock);
      sb.report_leftover();
      $display("Run covered %0d enqueues, %0d dequeues, %0d searches, %0d unused commands.",
               sb.cmd_seen[kfs_pkg::CMD_ENQUEUE], sb.cmd_seen[kfs_pkg::CMD_DEQUEUE],
               sb.cmd_seen[kfs_pkg::CMD_SEARCH], sb.cmd_seen[kfs_pkg::CMD_UNUSED]);
      $display("Replies checked: %0d; full %0d, empty %0d, found %0d, misses %0d; errors %0d.",
               sb.replies_seen, sb.full_hits, sb.empty_hits, sb.found_count, sb.misses,
               sb.errors);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
